[rtl/aes256_block_encrypt_assert.svh]
// Assertion macros for the AES-256 block encryptor.
`ifndef AES256_BLOCK_ENCRYPT_ASSERT_SVH
`define AES256_BLOCK_ENCRYPT_ASSERT_SVH
// Checks that a property holds on every clock edge outside reset.
`define AES_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a property holds on every clock edge, including during reset.
`define AES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES-256 package
// Shared payload types, constants and GF(2^8) helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned NumRounds   = 14;
    localparam int unsigned KeyRegIdxW  = 2;
    localparam int unsigned CfgIndexW   = 8;
    localparam int unsigned CfgDataW    = 64;

    localparam logic [KeyRegIdxW-1:0] REG_KEY_0_7   = 2'd0;
    localparam logic [KeyRegIdxW-1:0] REG_KEY_8_15  = 2'd1;
    localparam logic [KeyRegIdxW-1:0] REG_KEY_16_23 = 2'd2;
    localparam logic [KeyRegIdxW-1:0] REG_KEY_24_31 = 2'd3;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward S-box as a constant table.
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = t[x];
    endfunction

    // Byte n of a 128-bit state or key word lives in bits 8n+7:8n.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte rotation: new byte 0 is old byte 1.
    function automatic logic [31:0] rot_word(input logic [31:0] w);
        rot_word = {w[7:0], w[31:8]};
    endfunction

endpackage

[rtl/aes256_block_encrypt.sv]
// ----------------------------------------------------------------------------
// AES-256 block encryptor
// Fourteen-stage pipelined FIPS-197 AES-256 encryption with on-the-fly keys.
// ----------------------------------------------------------------------------
// The block accepts one 128-bit plaintext transaction per clock cycle while
// the output side does not stall, and returns the ciphertexts in order:
// each of the 14 rounds is one register stage with its own S-boxes and its
// own key schedule step, so the key travels alongside the data. The initial
// AddRoundKey sits in front of the first stage. The whole pipeline advances
// together; when the output is held off, every stage freezes and in_ready
// drops, so nothing is lost or repeated. The key registers are sampled at
// input acceptance, so key writes only need the pipeline to be drained.
`timescale 1ns / 1ps
module aes256_block_encrypt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  aes_pkg::plain_t                     in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output aes_pkg::cipher_t                    out_data,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [aes_pkg::CfgDataW-1:0]        cfg_data
);
    import aes_pkg::*;

    logic [63:0]  key_reg [0:3];
    logic [255:0] key_full;
    logic         advance;

    logic         stage_valid [0:NumRounds];
    logic [127:0] stage_state [0:NumRounds];
    logic [255:0] stage_key   [0:NumRounds];

    // Register writes; indexes above the key registers are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index[CfgIndexW-1:KeyRegIdxW] == '0))
        begin
            case (cfg_index[KeyRegIdxW-1:0])
                REG_KEY_0_7:   key_reg[0] <= cfg_data;
                REG_KEY_8_15:  key_reg[1] <= cfg_data;
                REG_KEY_16_23: key_reg[2] <= cfg_data;
                REG_KEY_24_31: key_reg[3] <= cfg_data;
                default:       key_reg[0] <= key_reg[0];
            endcase
        end
    end

    assign key_full = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    // The whole pipe moves whenever the last stage is empty or drained.
    assign advance  = !stage_valid[NumRounds] || out_ready;
    assign in_ready = advance;

    // Stage zero input: plaintext whitened with the first round key.
    assign stage_valid[0] = in_valid;
    assign stage_state[0] = {in_data.plain_high, in_data.plain_low} ^ key_full[127:0];
    assign stage_key[0]   = key_full;

    // Round constants for the key steps of odd rounds 1, 3, ... 13.
    function automatic logic [7:0] rcon_for(input int unsigned rnd);
        logic [7:0] r;
        r = 8'h01;
        for (int k = 2; k < 14; k += 2)
        begin
            if (k < rnd)
            begin
                r = xtime(r);
            end
        end
        rcon_for = r;
    endfunction

    for (genvar g = 1; g <= NumRounds; g++)
    begin : g_round
        aes_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .valid_in   (stage_valid[g-1]),
            .state_in   (stage_state[g-1]),
            .key_in     (stage_key[g-1]),
            .rcon_in    (rcon_for(g)),
            .last_round (g == NumRounds),
            .even_round ((g % 2) == 0),
            .valid_out  (stage_valid[g]),
            .state_out  (stage_state[g]),
            .key_out    (stage_key[g])
        );
    end

    assign out_valid            = stage_valid[NumRounds];
    assign out_data.cipher_low  = stage_state[NumRounds][63:0];
    assign out_data.cipher_high = stage_state[NumRounds][127:64];

`include "aes256_block_encrypt_assert.svh"

    // A stalled result must stay put until taken.
    `AES_ASSERT_CLK(a_hold_out, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result changed while stalled")
    // Input is taken exactly when the pipe can move.
    `AES_ASSERT_CLK(a_ready_rule, in_ready == (!out_valid || out_ready), "ready does not follow output stall")
    // An accepted item appears in the first stage in the next cycle.
    `AES_ASSERT_CLK(a_enter, (in_valid && in_ready) |=> stage_valid[1], "accepted item lost at stage one")
endmodule

[rtl/aes_round.sv]
// ----------------------------------------------------------------------------
// AES round stage
// One cipher round plus one key schedule step, registered, with stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_round (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         valid_in,
    input  logic [127:0] state_in,
    input  logic [255:0] key_in,
    input  logic [7:0]   rcon_in,
    input  logic         last_round,
    input  logic         even_round,
    output logic         valid_out,
    output logic [127:0] state_out,
    output logic [255:0] key_out
);
    import aes_pkg::*;

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [255:0] key_reg;
    logic [127:0] sub_shift;
    logic [127:0] mixed;
    logic [127:0] round_key;
    logic [127:0] state_next;
    logic [255:0] key_next;
    logic [31:0]  w_a [0:3];

    // The round key is the half of the key window selected by round parity;
    // the window slides by four words every round.
    assign round_key = even_round ? key_in[127:0] : key_in[255:128];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sub_shift[8*(r+4*c) +: 8] = sbox(state_in[8*(r+4*((c+r)%4)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3;
            a0 = sub_shift[32*c +: 8];
            a1 = sub_shift[32*c+8 +: 8];
            a2 = sub_shift[32*c+16 +: 8];
            a3 = sub_shift[32*c+24 +: 8];
            mixed[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            mixed[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            mixed[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            mixed[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        state_next = (last_round ? sub_shift : mixed) ^ round_key;
    end

    // Key step: on odd rounds the low half is refreshed with RotWord,
    // SubWord and rcon; on even rounds the high half with SubWord only.
    always_comb
    begin
        logic [31:0] t;
        key_next = key_in;
        if (!even_round)
        begin
            t = sub_word(rot_word(key_in[255:224])) ^ {24'd0, rcon_in};
            w_a[0] = key_in[31:0] ^ t;
            w_a[1] = key_in[63:32] ^ w_a[0];
            w_a[2] = key_in[95:64] ^ w_a[1];
            w_a[3] = key_in[127:96] ^ w_a[2];
            key_next[127:0] = {w_a[3], w_a[2], w_a[1], w_a[0]};
        end
        else
        begin
            t = sub_word(key_in[127:96]);
            w_a[0] = key_in[159:128] ^ t;
            w_a[1] = key_in[191:160] ^ w_a[0];
            w_a[2] = key_in[223:192] ^ w_a[1];
            w_a[3] = key_in[255:224] ^ w_a[2];
            key_next[255:128] = {w_a[3], w_a[2], w_a[1], w_a[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule

[test/tb_aes256_block_encrypt.sv]
// ----------------------------------------------------------------------------
// AES-256 block encryptor testbench
// Encrypts directed and random blocks under several keys and idle patterns
// and compares every ciphertext with a built-in FIPS-197 cipher model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_aes256_block_encrypt;
    import aes_pkg::*;

    // Indexes past the last key register; the block must ignore writes there.
    localparam logic [CfgIndexW-1:0] CFG_IDX_UNUSED_LO = 8'd4;
    localparam logic [CfgIndexW-1:0] CFG_IDX_UNUSED_HI = 8'd255;
    localparam int DRAIN_CYCLES  = 30;   // comfortably past the 14-stage pipeline
    localparam int STALL_LIMIT   = 4000; // cycles without any transaction
    localparam int LONG_HOLD     = 120;  // long receiver hold-off, in cycles
    localparam int NUM_PHASES    = 6;
    localparam int RAND_PER_PHASE = 158;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    plain_t           in_data;
    logic             out_valid;
    logic             out_ready;
    cipher_t          out_data;
    logic             cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    aes256_block_encrypt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: the key registers as the block should hold them.
    logic [63:0] key_regs [0:3];
    logic [7:0]  sbox_tab [0:255];

    plain_t  plain_q [$];      // blocks waiting to be offered
    cipher_t cipher_exp_q [$]; // ciphertexts still owed by the block

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold_req;
    int  hold_left;
    bit  in_taken;
    int  quiet_cycles;
    int  mismatches;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // The S-box is the GF(2^8) inverse (x^254) followed by the affine map.
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] pw;
        int e;
        inv = 8'h01;
        pw  = x;
        e   = 254;
        for (int i = 0; i < 8; i++) begin
            if (e & 1)
                inv = gf_mult(inv, pw);
            pw = gf_mult(pw, pw);
            e  = e >> 1;
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // Full AES-256 encryption of one block under the current key registers.
    function automatic cipher_t encrypt_block(input plain_t p);
        logic [7:0] w [0:239];
        logic [7:0] st [0:15];
        logic [7:0] tmp [0:15];
        logic [7:0] tw [0:3];
        logic [7:0] rcon;
        logic [7:0] first;
        logic [7:0] a0, a1, a2, a3;
        cipher_t c;
        for (int k = 0; k < 4; k++)
            for (int b = 0; b < 8; b++)
                w[8 * k + b] = key_regs[k][8 * b +: 8];
        rcon = 8'h01;
        for (int i = 8; i < 60; i++) begin
            for (int j = 0; j < 4; j++)
                tw[j] = w[4 * (i - 1) + j];
            if (i % 8 == 0) begin
                first = tw[0];
                tw[0] = sbox_tab[tw[1]] ^ rcon;
                tw[1] = sbox_tab[tw[2]];
                tw[2] = sbox_tab[tw[3]];
                tw[3] = sbox_tab[first];
                rcon  = gf_mult(rcon, 8'h02);
            end else if (i % 8 == 4) begin
                for (int j = 0; j < 4; j++)
                    tw[j] = sbox_tab[tw[j]];
            end
            for (int j = 0; j < 4; j++)
                w[4 * i + j] = w[4 * (i - 8) + j] ^ tw[j];
        end
        for (int b = 0; b < 8; b++) begin
            st[b]     = p.plain_low[8 * b +: 8];
            st[8 + b] = p.plain_high[8 * b +: 8];
        end
        for (int b = 0; b < 16; b++)
            st[b] ^= w[b];
        for (int r = 1; r <= 14; r++) begin
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    tmp[row + 4 * col] = sbox_tab[st[row + 4 * ((col + row) & 3)]];
            for (int b = 0; b < 16; b++)
                st[b] = tmp[b];
            if (r < 14) begin
                for (int col = 0; col < 4; col++) begin
                    a0 = st[4 * col];
                    a1 = st[4 * col + 1];
                    a2 = st[4 * col + 2];
                    a3 = st[4 * col + 3];
                    st[4 * col]     = gf_mult(a0, 8'h02) ^ gf_mult(a1, 8'h03) ^ a2 ^ a3;
                    st[4 * col + 1] = a0 ^ gf_mult(a1, 8'h02) ^ gf_mult(a2, 8'h03) ^ a3;
                    st[4 * col + 2] = a0 ^ a1 ^ gf_mult(a2, 8'h02) ^ gf_mult(a3, 8'h03);
                    st[4 * col + 3] = gf_mult(a0, 8'h03) ^ a1 ^ a2 ^ gf_mult(a3, 8'h02);
                end
            end
            for (int b = 0; b < 16; b++)
                st[b] ^= w[16 * r + b];
        end
        for (int b = 0; b < 8; b++) begin
            c.cipher_low[8 * b +: 8]  = st[b];
            c.cipher_high[8 * b +: 8] = st[8 + b];
        end
        return c;
    endfunction

    // Monitor: everything is sampled at the rising edge, before the block's
    // own registers update in the same time step.
    always @(posedge clk) begin
        cipher_t exp_c;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                cipher_exp_q.push_back(encrypt_block(in_data));
            if (out_valid && out_ready) begin
                if (cipher_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected ciphertext transaction %h", out_data);
                end else begin
                    exp_c = cipher_exp_q.pop_front();
                    if (out_data.cipher_low !== exp_c.cipher_low
                        || out_data.cipher_high !== exp_c.cipher_high) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: ciphertext mismatch: expected high %h low %h, got high %h low %h",
                                     exp_c.cipher_high, exp_c.cipher_low,
                                     out_data.cipher_high, out_data.cipher_low);
                    end
                end
            end
            // Watchdog: only cycles where neither side moves a transaction count.
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Driver: a new block goes out only once the previous one was taken, so
    // valid and the payload hold steady while the block is stalled.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_data  <= plain_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested so the
    // pipeline fills and pushes back on the input.
    always @(negedge clk) begin
        if (long_hold_req && hold_left == 0) begin
            long_hold_req = 1'b0;
            hold_left    <= LONG_HOLD;
            out_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= 3)
            key_regs[idx[1:0]] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every block has been sent and answered, then let the
    // pipeline settle before touching the key.
    task automatic wait_drained();
        while (plain_q.size() != 0 || in_valid || cipher_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [63:0] k [0:3];
        plain_t p;
        for (int i = 0; i < 256; i++)
            sbox_tab[i] = sbox_calc(i[7:0]);
        for (int i = 0; i < 4; i++)
            key_regs[i] = 64'h0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;
        hold_left      = 0;
        in_taken       = 1'b0;
        quiet_cycles   = 0;
        mismatches     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset key of all zeros.
        plain_q.push_back('{plain_high: 64'h0, plain_low: 64'h0});
        plain_q.push_back('{plain_high: '1, plain_low: '1});
        plain_q.push_back('{plain_high: 64'h0, plain_low: '1});
        plain_q.push_back('{plain_high: 64'h8000_0000_0000_0000, plain_low: 64'h1});
        plain_q.push_back('{plain_high: 64'haaaa_aaaa_aaaa_aaaa, plain_low: 64'h5555_5555_5555_5555});
        wait_drained();

        // The FIPS-197 example key, with a known answer block; writes to
        // indexes beyond the key registers must leave the key alone.
        write_reg(CfgIndexW'(REG_KEY_0_7),   64'h0706_0504_0302_0100);
        write_reg(CfgIndexW'(REG_KEY_8_15),  64'h0f0e_0d0c_0b0a_0908);
        write_reg(CfgIndexW'(REG_KEY_16_23), 64'h1716_1514_1312_1110);
        write_reg(CfgIndexW'(REG_KEY_24_31), 64'h1f1e_1d1c_1b1a_1918);
        write_reg(CFG_IDX_UNUSED_LO, '1);
        write_reg(CFG_IDX_UNUSED_HI, 64'hdead_beef_0bad_f00d);
        plain_q.push_back('{plain_high: 64'hffee_ddcc_bbaa_9988,
                            plain_low: 64'h7766_5544_3322_1100});
        plain_q.push_back('{plain_high: 64'h0, plain_low: 64'h0});
        plain_q.push_back('{plain_high: '1, plain_low: '1});
        for (int b = 0; b < 8; b++)
            plain_q.push_back('{plain_high: 64'h1 << (8 * b + 7), plain_low: 64'h1 << (8 * b)});
        wait_drained();

        // Random part: each phase gets its own key and one of four idle patterns. The key
        // list starts with the extremes, all ones then all zeros.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int r = 0; r < 4; r++)
                k[r] = (ph == 0) ? '1 : (ph == 1) ? 64'h0 : rand_word();
            for (int r = 0; r < 4; r++)
                write_reg(r[CfgIndexW-1:0], k[r]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                p.plain_low  = rand_word();
                p.plain_high = rand_word();
                plain_q.push_back(p);
            end
            // In the first phase the receiver holds off for a long time while
            // the sender keeps offering, so the pipeline backs up fully.
            if (ph == 0) begin
                repeat (5) @(posedge clk);
                long_hold_req = 1'b1;
            end
            // The sender then pauses until every answer is in before the
            // next key is written.
            wait_drained();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
